### hdl/rfad_pkg.sv
package rfad_pkg;

  // Default sizes of the register file
  localparam int unsigned NUM_REGS_DEF   = 32;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed widths of the channel fields
  localparam int unsigned OP_W        = 3;
  localparam int unsigned IDX_FIELD_W = 5;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned IDX_SPAN    = 1 << IDX_FIELD_W;

  typedef logic [OP_W-1:0] op_t;

  // Operation codes
  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_MUL = 3'd2;
  localparam op_t OP_DIV = 3'd3;
  localparam op_t OP_MOD = 3'd4;
  localparam op_t OP_LDI = 3'd5;

  // Command from the sequencer to the serial ALU
  typedef struct packed {
    logic start;
    op_t  op;
  } alu_cmd_t;

endpackage

### hdl/rfad_ifs.sv
// Instruction channel
interface rfad_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [rfad_pkg::OP_W-1:0]              req_type;
  logic [rfad_pkg::IDX_FIELD_W-1:0]       dest_index;
  logic [rfad_pkg::IDX_FIELD_W-1:0]       src_a_index;
  logic [rfad_pkg::IDX_FIELD_W-1:0]       src_b_index;
  logic signed [rfad_pkg::VAL_W-1:0]      immediate_value;

  modport source (
    output valid, req_type, dest_index, src_a_index, src_b_index, immediate_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, dest_index, src_a_index, src_b_index, immediate_value,
    output ready
  );
endinterface

// Result channel
interface rfad_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic [rfad_pkg::IDX_FIELD_W-1:0]       written_index;
  logic signed [rfad_pkg::VAL_W-1:0]      written_value;
  logic                                   write_done;
  logic                                   div_by_zero;

  modport source (
    output valid, written_index, written_value, write_done, div_by_zero,
    input  ready
  );
  modport sink (
    input  valid, written_index, written_value, write_done, div_by_zero,
    output ready
  );
endinterface

### hdl/register_file_alu_div_mod_unit.sv
// Three-operand integer ALU over a register file of NUM_REGS signed words.
// req carries one instruction per transfer: req_type, dest_index,
// src_a_index, src_b_index and immediate_value (load immediate only).
// rsp carries one result per instruction: the target index, the target's
// value after the instruction, whether it was written and a divide-by-zero
// flag. Indices are reduced modulo NUM_REGS.
// One instruction is in flight at a time. After the transfer the sequencer
// reads source a, source b and then the target from the single read port;
// add, sub, mul, div and mod then run in the serial ALU, one bit per cycle,
// followed by a write-back state. Load immediate, a zero divisor and unused
// codes skip the ALU and go straight to write-back.
// A new instruction is taken only once the sequencer is idle again, after
// the write-back of the previous one.
// A finished result waits in an output register, so the next instruction is
// taken while it is not yet collected; write-back of the one after stalls
// until rsp takes the waiting result.
// Reset (rst, synchronous) empties the output register and marks every
// register entry invalid; invalid entries read as zero, so the file reads
// all zeros right after reset with no clearing pass.
module register_file_alu_div_mod_unit #(
  parameter int unsigned NUM_REGS   = rfad_pkg::NUM_REGS_DEF,
  parameter int unsigned DATA_WIDTH = rfad_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  rfad_req_if.sink          req,
  rfad_rsp_if.source        rsp
);

  localparam int unsigned IDX_W = $clog2(NUM_REGS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RA   = 3'd1;
  localparam logic [2:0] S_RB   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EV   = 3'd4;
  localparam logic [2:0] S_RUN  = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;

  logic [2:0]                   state;
  rfad_pkg::op_t                op_q;
  logic [IDX_W-1:0]             dst_q, sa_q, sb_q;
  logic signed [rfad_pkg::VAL_W-1:0] imm_q;
  logic signed [DATA_WIDTH-1:0] opa, opb, res;
  logic                         wr_q, dz_q;
  logic [NUM_REGS-1:0]          valid;
  logic                         rd_vld;

  logic [IDX_W-1:0]             idx_map [rfad_pkg::IDX_SPAN];
  logic [IDX_W-1:0]             raddr;
  logic [DATA_WIDTH-1:0]        rdata, rword;
  logic                         ram_we;
  logic                         accept, can_load, out_take;
  rfad_pkg::alu_cmd_t           alu_cmd;
  logic                         alu_done;
  logic signed [DATA_WIDTH-1:0] alu_result;
  logic                         is_alu_op, is_div_op;

  logic                              out_full;
  logic [rfad_pkg::IDX_FIELD_W-1:0]  out_idx;
  logic signed [rfad_pkg::VAL_W-1:0] out_val;
  logic                              out_wr, out_dz;

  // Index reduction table, folded at elaboration
  for (genvar i = 0; i < rfad_pkg::IDX_SPAN; i++) begin : g_idx
    localparam int unsigned RED = i % NUM_REGS;
    assign idx_map[i] = IDX_W'(RED);
  end

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_take  = out_full && rsp.ready;
  assign can_load  = !out_full || rsp.ready;

  // Read address follows the read sequence: source a, source b, target
  always_comb begin
    unique case (state)
      S_RA:    raddr = sa_q;
      S_RB:    raddr = sb_q;
      default: raddr = dst_q;
    endcase
  end

  assign rword  = rd_vld ? rdata : '0;
  assign ram_we = (state == S_WB) && wr_q && can_load;

  assign is_div_op = (op_q == rfad_pkg::OP_DIV) || (op_q == rfad_pkg::OP_MOD);
  assign is_alu_op = (op_q == rfad_pkg::OP_ADD) || (op_q == rfad_pkg::OP_SUB) ||
                     (op_q == rfad_pkg::OP_MUL) || (is_div_op && (opb != '0));

  assign alu_cmd.start = (state == S_EV) && is_alu_op;
  assign alu_cmd.op    = op_q;

  rfad_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dst_q),
    .wdata (res),
    .raddr (raddr),
    .rdata (rdata)
  );

  rfad_serial_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (alu_cmd),
    .a      (opa),
    .b      (opb),
    .done   (alu_done),
    .result (alu_result)
  );

  // Sequencer and entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RA;
          end
        end
        S_RA:  state <= S_RB;
        S_RB:  state <= S_RD;
        S_RD:  state <= S_EV;
        S_EV:  state <= is_alu_op ? S_RUN : S_WB;
        S_RUN: begin
          if (alu_done) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (ram_we) begin
        valid[dst_q] <= 1'b1;
      end
    end
  end

  // Instruction fields, operands and result
  always_ff @(posedge clk) begin
    rd_vld <= valid[raddr];
    if (accept) begin
      op_q  <= req.req_type;
      dst_q <= idx_map[req.dest_index];
      sa_q  <= idx_map[req.src_a_index];
      sb_q  <= idx_map[req.src_b_index];
      imm_q <= req.immediate_value;
    end
    unique case (state)
      S_RB: opa <= rword;
      S_RD: opb <= rword;
      S_EV: begin
        // rword is the target's current value here
        dz_q <= is_div_op && (opb == '0);
        wr_q <= is_alu_op || (op_q == rfad_pkg::OP_LDI);
        if (op_q == rfad_pkg::OP_LDI) begin
          res <= DATA_WIDTH'(imm_q);
        end else begin
          res <= rword;
        end
      end
      S_RUN: begin
        if (alu_done) begin
          res <= alu_result;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if ((state == S_WB) && can_load) begin
      out_full <= 1'b1;
    end else if (out_take) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_WB) && can_load) begin
      out_idx <= rfad_pkg::IDX_FIELD_W'(dst_q);
      out_val <= rfad_pkg::VAL_W'(res);
      out_wr  <= wr_q;
      out_dz  <= dz_q;
    end
  end

  assign rsp.valid         = out_full;
  assign rsp.written_index = out_idx;
  assign rsp.written_value = out_val;
  assign rsp.write_done    = out_wr;
  assign rsp.div_by_zero   = out_dz;

endmodule

### hdl/rfad_ram.sv
// Generic RAM: one write port, one read port, registered read data
module rfad_ram #(
  parameter int unsigned WIDTH = rfad_pkg::DATA_WIDTH_DEF,
  parameter int unsigned DEPTH = rfad_pkg::NUM_REGS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/rfad_serial_alu.sv
// Serial ALU: add/sub one bit per cycle, shift-add multiply and restoring
// divide one bit per cycle, then a sign fixup step.
// a and b must stay stable from start until done.
module rfad_serial_alu #(
  parameter int unsigned DATA_WIDTH = rfad_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rfad_pkg::alu_cmd_t           cmd,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH + 1);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_RUN  = 2'd1;
  localparam logic [1:0] A_FIN  = 2'd2;

  logic [1:0]            state;
  rfad_pkg::op_t         op;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] x;
  logic [DATA_WIDTH-1:0] y;
  logic [DATA_WIDTH-1:0] acc;
  logic                  carry;
  logic                  neg_q;
  logic                  neg_a;

  logic                  na, nb;
  logic [DATA_WIDTH-1:0] a_u, b_u, ma, mb;
  logic                  sbit, cnext;
  logic [DATA_WIDTH-1:0] prod_sum;
  logic [DATA_WIDTH:0]   shifted, trial;
  logic [DATA_WIDTH-1:0] quo_fix, mod_fix;

  // Operand magnitudes for the divider
  assign a_u = a;
  assign b_u = b;
  assign na  = a[DATA_WIDTH-1];
  assign nb  = b[DATA_WIDTH-1];
  assign ma  = na ? (~a_u + 1'b1) : a_u;
  assign mb  = nb ? (~b_u + 1'b1) : b_u;

  // One bit of the serial adder
  assign sbit  = x[0] ^ y[0] ^ carry;
  assign cnext = (x[0] & y[0]) | (carry & (x[0] ^ y[0]));

  // One partial product
  assign prod_sum = acc + (y[0] ? x : '0);

  // One restoring divide step: remainder in acc, quotient shifts into x
  assign shifted = {acc, x[DATA_WIDTH-1]};
  assign trial   = shifted - {1'b0, y};

  // Sign fixup
  assign quo_fix = neg_q ? (~x + 1'b1) : x;
  assign mod_fix = (neg_a && (acc != '0)) ? (b_u - acc) : acc;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (cmd.start) begin
            state <= A_RUN;
          end
        end
        A_RUN: begin
          if (cnt == CNT_W'(1)) begin
            state <= A_FIN;
          end
        end
        A_FIN: begin
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      A_IDLE: begin
        if (cmd.start) begin
          op    <= cmd.op;
          cnt   <= CNT_W'(DATA_WIDTH);
          neg_q <= na ^ nb;
          neg_a <= na;
          carry <= (cmd.op == rfad_pkg::OP_SUB);
          acc   <= '0;
          if (cmd.op == rfad_pkg::OP_DIV || cmd.op == rfad_pkg::OP_MOD) begin
            x <= ma;
            y <= mb;
          end else if (cmd.op == rfad_pkg::OP_SUB) begin
            x <= a_u;
            y <= ~b_u;
          end else begin
            x <= a_u;
            y <= b_u;
          end
        end
      end
      A_RUN: begin
        cnt <= cnt - 1'b1;
        unique case (op)
          rfad_pkg::OP_ADD, rfad_pkg::OP_SUB: begin
            x     <= {sbit, x[DATA_WIDTH-1:1]};
            y     <= y >> 1;
            carry <= cnext;
          end
          rfad_pkg::OP_MUL: begin
            acc <= prod_sum;
            x   <= x << 1;
            y   <= y >> 1;
          end
          rfad_pkg::OP_DIV, rfad_pkg::OP_MOD: begin
            if (!trial[DATA_WIDTH]) begin
              acc <= trial[DATA_WIDTH-1:0];
              x   <= {x[DATA_WIDTH-2:0], 1'b1};
            end else begin
              acc <= shifted[DATA_WIDTH-1:0];
              x   <= {x[DATA_WIDTH-2:0], 1'b0};
            end
          end
          default: ;
        endcase
      end
      A_FIN: begin
        unique case (op)
          rfad_pkg::OP_MUL: result <= acc;
          rfad_pkg::OP_DIV: result <= quo_fix;
          rfad_pkg::OP_MOD: result <= mod_fix;
          default:          result <= x;
        endcase
      end
      default: ;
    endcase
  end

endmodule
